// File: src/lcmc_pkg.sv
`timescale 1ns / 1ps

package lcmc_pkg;

    localparam int ENTRIES = 64;
    localparam int KEY_W   = 32;
    localparam int CAP_W   = 7;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OCC_W-1:0] occ_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic lookup;
        logic update;
        idx_t upto;
        occ_t occupancy;
        key_t search;
    } cell_ctrl_t;

endpackage

// File: src/lcmc_cell.sv
`timescale 1ns / 1ps

module lcmc_cell
(
    input  logic                clk,
    input  lcmc_pkg::idx_t      cell_idx,
    input  lcmc_pkg::cell_ctrl_t ctrl,
    input  lcmc_pkg::key_t      prev_key,
    output lcmc_pkg::key_t      key,
    output logic                match,
    output lcmc_pkg::key_t      tail_key
);

    lcmc_pkg::key_t key_reg;
    lcmc_pkg::key_t key_next;
    logic           match_reg;
    logic           match_next;
    logic           occupied;
    logic           is_tail;
    logic           shift;

    assign occupied = lcmc_pkg::OCC_W'(cell_idx) < ctrl.occupancy;
    assign is_tail  = (lcmc_pkg::OCC_W'(cell_idx) + lcmc_pkg::OCC_W'(1)) == ctrl.occupancy;
    assign shift    = ctrl.update && (cell_idx <= ctrl.upto);

    always_comb
    begin
        key_next = key_reg;
        if (shift)
        begin
            key_next = (cell_idx == '0) ? ctrl.search : prev_key;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.lookup)
        begin
            match_next = occupied && (key_reg == ctrl.search);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
    end

    assign key      = key_reg;
    assign match    = match_reg;
    assign tail_key = is_tail ? key_reg : '0;

endmodule

// File: src/lru_cache_miss_counter.sv
`timescale 1ns / 1ps
// channel | signals                                           | transfer when
// --------+---------------------------------------------------+----------------------
// in      | in_valid, in_stall, access_key                    | in_valid && !in_stall
// out     | out_valid, out_stall, hit, evicted_valid,         | out_valid && !out_stall
//         | evicted_key, miss_total                           |
// cfg     | cfg_wr_en, cfg_wr_data (capacity)                 | cfg_wr_en
//
// An access runs ST_LOOKUP, the parallel tag compare in every cell, then ST_UPDATE, the encode
// and the shift of the recency chain. A new key is taken in the shift cycle.
// Reset clears the occupancy, the miss count and the control; capacity resets to 64.
// A result waiting under out_stall holds the shift cycle, and with it the input side.

module lru_cache_miss_counter
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                access_key,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic                       evicted_valid,
    output logic [31:0]                evicted_key,
    output logic [31:0]                miss_total,
    input  logic                       cfg_wr_en,
    input  logic [lcmc_pkg::CAP_W-1:0] cfg_wr_data
);

    lcmc_pkg::state_t state_reg, state_next;
    logic [lcmc_pkg::CAP_W-1:0] cap_reg;
    lcmc_pkg::occ_t occ_reg, occ_next;
    logic [lcmc_pkg::CNT_W-1:0] miss_reg, miss_next;
    lcmc_pkg::key_t search_reg;
    lcmc_pkg::key_t ev_key_reg;
    logic out_valid_reg, out_valid_next;
    logic hit_reg;
    logic ev_valid_reg;
    lcmc_pkg::key_t ev_out_reg;

    lcmc_pkg::key_t cell_key [lcmc_pkg::ENTRIES];
    lcmc_pkg::key_t cell_tail [lcmc_pkg::ENTRIES];
    logic [lcmc_pkg::ENTRIES-1:0] match_vec;
    lcmc_pkg::cell_ctrl_t ctrl;

    logic in_accept;
    logic advance;
    logic any_hit;
    logic full;
    lcmc_pkg::idx_t pos;
    lcmc_pkg::occ_t eff_cap;
    lcmc_pkg::key_t tail_or;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == lcmc_pkg::ST_IDLE) ||
                         ((state_reg == lcmc_pkg::ST_UPDATE) && advance));
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = lcmc_pkg::OCC_W'(1);
        end
        else if (32'(cap_reg) > lcmc_pkg::ENTRIES)
        begin
            eff_cap = lcmc_pkg::OCC_W'(lcmc_pkg::ENTRIES);
        end
        else
        begin
            eff_cap = lcmc_pkg::OCC_W'(cap_reg);
        end
    end

    assign full    = occ_reg >= eff_cap;
    assign any_hit = |match_vec;

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < lcmc_pkg::ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                pos = pos | lcmc_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < lcmc_pkg::ENTRIES; i++)
        begin
            tail_or = tail_or | cell_tail[i];
        end
    end

    always_comb
    begin
        ctrl.lookup    = (state_reg == lcmc_pkg::ST_LOOKUP);
        ctrl.update    = (state_reg == lcmc_pkg::ST_UPDATE) && advance;
        ctrl.occupancy = occ_reg;
        ctrl.search    = search_reg;
        if (any_hit)
        begin
            ctrl.upto = pos;
        end
        else if (full)
        begin
            ctrl.upto = lcmc_pkg::IDX_W'(occ_reg - lcmc_pkg::OCC_W'(1));
        end
        else
        begin
            ctrl.upto = lcmc_pkg::IDX_W'(occ_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < lcmc_pkg::ENTRIES; g++)
        begin : g_cell
            lcmc_pkg::key_t prev;
            if (g == 0)
            begin : g_head
                assign prev = search_reg;
            end
            else
            begin : g_body
                assign prev = cell_key[g-1];
            end
            lcmc_cell u_cell
            (
                .clk      (clk),
                .cell_idx (lcmc_pkg::IDX_W'(g)),
                .ctrl     (ctrl),
                .prev_key (prev),
                .key      (cell_key[g]),
                .match    (match_vec[g]),
                .tail_key (cell_tail[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcmc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = lcmc_pkg::ST_LOOKUP;
                end
            end
            lcmc_pkg::ST_LOOKUP:
            begin
                state_next = lcmc_pkg::ST_UPDATE;
            end
            lcmc_pkg::ST_UPDATE:
            begin
                if (in_accept)
                begin
                    state_next = lcmc_pkg::ST_LOOKUP;
                end
                else if (advance)
                begin
                    state_next = lcmc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next  = occ_reg;
        miss_next = miss_reg;
        if (ctrl.update && !any_hit)
        begin
            if (!full)
            begin
                occ_next = occ_reg + lcmc_pkg::OCC_W'(1);
            end
            if (miss_reg != '1)
            begin
                miss_next = miss_reg + lcmc_pkg::CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcmc_pkg::ST_IDLE;
            cap_reg       <= lcmc_pkg::CAP_W'(64);
            occ_reg       <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            search_reg <= access_key;
        end
        if (ctrl.lookup)
        begin
            ev_key_reg <= tail_or;
        end
        if (ctrl.update)
        begin
            hit_reg      <= any_hit;
            ev_valid_reg <= !any_hit && full;
            ev_out_reg   <= (!any_hit && full) ? ev_key_reg : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_out_reg;
    assign miss_total    = miss_reg;

    // occupied keys are unique, so at most one cell matches
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcmc_pkg::ST_UPDATE) |-> $onehot0(match_vec))
        else $error("more than one cell matched");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(occ_reg) <= lcmc_pkg::ENTRIES)
        else $error("occupancy beyond entry count");

    a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (miss_reg >= $past(miss_reg)))
        else $error("miss count went down");

    a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lcmc_pkg::ST_UPDATE))
        else $error("result raised outside the update cycle");

endmodule
